/* design/rcsc_pkg.sv */
package rcsc_pkg;

  localparam int RAW_W      = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int OUT_W      = 19;
  localparam int THR_W      = 18;
  localparam int MS_W       = 16;

  // Fixed gains and thresholds of the conditioner.
  localparam logic [15:0]      THROTTLE_GAIN_Q12     = 16'd4096;
  localparam logic [RAW_W-1:0] ARM_CHANNEL_THRESHOLD = 11'd1000;

  localparam logic [14:0] Q14_ONE = 15'd16384;
  localparam logic [16:0] Q16_ONE = 17'd65536;

  // Item kinds.
  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_IN_MIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPAN_RECIP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ROLL_GAIN  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH_GAIN = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_YAW_GAIN   = 3'd7;

  // Stick channels in processing order.
  localparam logic [1:0] CH_ROLL     = 2'd0;
  localparam logic [1:0] CH_PITCH    = 2'd1;
  localparam logic [1:0] CH_THROTTLE = 2'd2;
  localparam logic [1:0] CH_YAW      = 2'd3;

  typedef enum logic [2:0] {
    STEP_NONE,
    STEP_FRAC,
    STEP_GAIN,
    STEP_EMA,
    STEP_WB
  } dp_step_e;

  typedef struct packed {
    logic       capture;
    logic       tick;
    dp_step_e   step;
    logic [1:0] ch;
    logic       load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic [RAW_W-1:0] in_min;
    logic [23:0]      span_recip;
    logic [14:0]      deadband;
    logic [16:0]      alpha;
    logic [MS_W-1:0]  timeout_ms;
    logic [15:0]      roll_gain;
    logic [15:0]      pitch_gain;
    logic [15:0]      yaw_gain;
  } cfg_t;

endpackage

/* design/rcsc_if.sv */
interface rcsc_in_if import rcsc_pkg::*;;
  logic             valid;
  logic             ready;
  logic             op;
  logic [RAW_W-1:0] roll_raw;
  logic [RAW_W-1:0] pitch_raw;
  logic [RAW_W-1:0] throttle_raw;
  logic [RAW_W-1:0] yaw_raw;
  logic [RAW_W-1:0] arm_raw;
  logic             failsafe_in;

  modport source (
    output valid, op, roll_raw, pitch_raw, throttle_raw, yaw_raw, arm_raw, failsafe_in,
    input  ready
  );
  modport sink (
    input  valid, op, roll_raw, pitch_raw, throttle_raw, yaw_raw, arm_raw, failsafe_in,
    output ready
  );
endinterface

interface rcsc_out_if import rcsc_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] roll_out;
  logic signed [OUT_W-1:0] pitch_out;
  logic        [THR_W-1:0] throttle_out;
  logic signed [OUT_W-1:0] yaw_out;
  logic                    signal_lost;
  logic                    armed;

  modport source (
    output valid, roll_out, pitch_out, throttle_out, yaw_out, signal_lost, armed,
    input  ready
  );
  modport sink (
    input  valid, roll_out, pitch_out, throttle_out, yaw_out, signal_lost, armed,
    output ready
  );
endinterface

/* design/rcsc_cfg_regs.sv */
module rcsc_cfg_regs import rcsc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.in_min     <= 11'd172;
      cfg_q.span_recip <= 24'd670972;
      cfg_q.deadband   <= 15'd819;
      cfg_q.alpha      <= 17'd19661;
      cfg_q.timeout_ms <= 16'd100;
      cfg_q.roll_gain  <= 16'd4096;
      cfg_q.pitch_gain <= 16'd4096;
      cfg_q.yaw_gain   <= 16'd4096;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IN_MIN:     cfg_q.in_min     <= cfg_wdata_i[10:0];
        CFG_SPAN_RECIP: cfg_q.span_recip <= cfg_wdata_i[23:0];
        CFG_DEADBAND:   cfg_q.deadband   <= cfg_wdata_i[14:0];
        CFG_ALPHA:      cfg_q.alpha      <= cfg_wdata_i[16:0];
        CFG_TIMEOUT_MS: cfg_q.timeout_ms <= cfg_wdata_i[15:0];
        CFG_ROLL_GAIN:  cfg_q.roll_gain  <= cfg_wdata_i[15:0];
        CFG_PITCH_GAIN: cfg_q.pitch_gain <= cfg_wdata_i[15:0];
        CFG_YAW_GAIN:   cfg_q.yaw_gain   <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* design/rcsc_datapath.sv */
module rcsc_datapath import rcsc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dp_cmd_t                 cmd_i,
  input  cfg_t                    cfg_i,
  input  logic [RAW_W-1:0]        roll_raw_i,
  input  logic [RAW_W-1:0]        pitch_raw_i,
  input  logic [RAW_W-1:0]        throttle_raw_i,
  input  logic [RAW_W-1:0]        yaw_raw_i,
  input  logic [RAW_W-1:0]        arm_raw_i,
  input  logic                    failsafe_in_i,
  output logic signed [OUT_W-1:0] roll_out_o,
  output logic signed [OUT_W-1:0] pitch_out_o,
  output logic        [THR_W-1:0] throttle_out_o,
  output logic signed [OUT_W-1:0] yaw_out_o,
  output logic                    signal_lost_o,
  output logic                    armed_o
);

  logic [RAW_W-1:0]        raw_q [4];
  logic signed [OUT_W-1:0] filt_q [4];
  logic [MS_W-1:0]         ms_q;
  logic                    failsafe_held_q;
  logic                    armed_held_q;
  logic signed [44:0]      prod_q;

  logic signed [OUT_W-1:0] roll_q, pitch_q, yaw_q;
  logic        [THR_W-1:0] throttle_q;
  logic                    lost_q, armed_q;

  logic [RAW_W-1:0]        raw_sel;
  logic [RAW_W-1:0]        diff;
  logic signed [OUT_W-1:0] filt_sel;
  logic [18:0]             frac_raw;
  logic [14:0]             frac;
  logic signed [16:0]      x_bip;
  logic [16:0]             x_mag;
  logic signed [16:0]      gain_x;
  logic [15:0]             scale;
  logic signed [OUT_W-1:0] scaled;
  logic signed [19:0]      ema_d;
  logic [16:0]             alpha_c;
  logic signed [19:0]      filt_inc;
  logic signed [19:0]      filt_sum;
  logic signed [24:0]      mul_a;
  logic signed [19:0]      mul_b;

  always_comb begin
    raw_sel  = raw_q[cmd_i.ch];
    filt_sel = filt_q[cmd_i.ch];
    diff     = (raw_sel >= cfg_i.in_min) ? (raw_sel - cfg_i.in_min) : '0;

    // Fraction of full stroke, saturated at one.
    frac_raw = prod_q[34:16];
    frac     = (frac_raw > 19'(Q14_ONE)) ? Q14_ONE : frac_raw[14:0];

    x_bip = $signed({1'b0, frac, 1'b0}) - $signed({2'b00, Q14_ONE});
    x_mag = x_bip[16] ? 17'(-x_bip) : 17'(x_bip);

    case (cmd_i.ch)
      CH_ROLL:  scale = cfg_i.roll_gain;
      CH_PITCH: scale = cfg_i.pitch_gain;
      CH_YAW:   scale = cfg_i.yaw_gain;
      default:  scale = THROTTLE_GAIN_Q12;
    endcase

    if (cmd_i.ch == CH_THROTTLE) begin
      gain_x = $signed({2'b00, frac});
    end else if (x_mag < {2'b00, cfg_i.deadband}) begin
      gain_x = '0;
    end else begin
      gain_x = x_bip;
    end

    // The EMA is computed as prev + alpha*(x - prev) >> 16, which floors the same way.
    scaled   = $signed(prod_q[30:12]);
    ema_d    = $signed({scaled[OUT_W-1], scaled}) - $signed({filt_sel[OUT_W-1], filt_sel});
    alpha_c  = (cfg_i.alpha > Q16_ONE) ? Q16_ONE : cfg_i.alpha;
    filt_inc = $signed(prod_q[35:16]);
    filt_sum = $signed({filt_sel[OUT_W-1], filt_sel}) + filt_inc;

    mul_a = '0;
    mul_b = '0;
    case (cmd_i.step)
      STEP_FRAC: begin
        mul_a = $signed({1'b0, cfg_i.span_recip});
        mul_b = $signed({9'b0, diff});
      end
      STEP_GAIN: begin
        mul_a = $signed({9'b0, scale});
        mul_b = $signed({{3{gain_x[16]}}, gain_x});
      end
      STEP_EMA: begin
        mul_a = $signed({8'b0, alpha_c});
        mul_b = ema_d;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= 45'(mul_a * mul_b);
    if (cmd_i.capture) begin
      raw_q[CH_ROLL]     <= roll_raw_i;
      raw_q[CH_PITCH]    <= pitch_raw_i;
      raw_q[CH_THROTTLE] <= throttle_raw_i;
      raw_q[CH_YAW]      <= yaw_raw_i;
    end
    if (cmd_i.load_out) begin
      roll_q     <= filt_q[CH_ROLL];
      pitch_q    <= filt_q[CH_PITCH];
      throttle_q <= filt_q[CH_THROTTLE][THR_W-1:0];
      yaw_q      <= filt_q[CH_YAW];
      lost_q     <= failsafe_held_q || (ms_q > cfg_i.timeout_ms);
      armed_q    <= armed_held_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        filt_q[i] <= '0;
      end
      ms_q            <= '1;
      failsafe_held_q <= 1'b0;
      armed_held_q    <= 1'b0;
    end else begin
      if (cmd_i.step == STEP_WB) begin
        filt_q[cmd_i.ch] <= filt_sum[OUT_W-1:0];
      end
      if (cmd_i.capture) begin
        ms_q            <= '0;
        failsafe_held_q <= failsafe_in_i;
        armed_held_q    <= (arm_raw_i > ARM_CHANNEL_THRESHOLD);
      end else if (cmd_i.tick && (ms_q != '1)) begin
        ms_q <= ms_q + 1'b1;
      end
    end
  end

  assign roll_out_o     = roll_q;
  assign pitch_out_o    = pitch_q;
  assign throttle_out_o = throttle_q;
  assign yaw_out_o      = yaw_q;
  assign signal_lost_o  = lost_q;
  assign armed_o        = armed_q;

  a_ms_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.tick && !cmd_i.capture && ms_q == '1) |=> ms_q == '1)
    else $error("millisecond counter wrapped");

  a_throttle_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step == STEP_WB && cmd_i.ch == CH_THROTTLE)
      |=> !filt_q[CH_THROTTLE][OUT_W-1])
    else $error("throttle filter went negative");

endmodule

/* design/rcsc_ctrl.sv */
module rcsc_ctrl import rcsc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_op_i,
  output logic    in_ready_o,
  input  logic    out_ready_i,
  output logic    out_valid_o,
  output dp_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FRAC,
    S_GAIN,
    S_EMA,
    S_WB,
    S_DONE
  } state_e;

  state_e     state_q;
  logic [1:0] ch_q;
  logic       out_valid_q;

  logic accept;
  logic out_free;
  logic load;

  always_comb begin
    in_ready_o = (state_q == S_IDLE);
    accept     = in_valid_i && in_ready_o;
    out_free   = !out_valid_q || out_ready_i;
    load       = (state_q == S_DONE) && out_free;

    cmd_o.capture  = accept && (in_op_i == OP_FRAME);
    cmd_o.tick     = accept && (in_op_i == OP_TICK);
    cmd_o.ch       = ch_q;
    cmd_o.load_out = load;
    unique case (state_q)
      S_FRAC:  cmd_o.step = STEP_FRAC;
      S_GAIN:  cmd_o.step = STEP_GAIN;
      S_EMA:   cmd_o.step = STEP_EMA;
      S_WB:    cmd_o.step = STEP_WB;
      default: cmd_o.step = STEP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ch_q        <= CH_ROLL;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            ch_q    <= CH_ROLL;
            state_q <= (in_op_i == OP_FRAME) ? S_FRAC : S_DONE;
          end
        end
        S_FRAC: state_q <= S_GAIN;
        S_GAIN: state_q <= S_EMA;
        S_EMA:  state_q <= S_WB;
        S_WB: begin
          if (ch_q == CH_YAW) begin
            ch_q    <= CH_ROLL;
            state_q <= S_DONE;
          end else begin
            ch_q    <= ch_q + 2'd1;
            state_q <= S_FRAC;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

  a_last_channel_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WB && ch_q == CH_YAW) |=> (state_q == S_DONE))
    else $error("frame did not finish after the last channel");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (out_valid_q && state_q == S_IDLE))
    else $error("result load did not raise valid");

  a_idle_channel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_DONE) |-> (ch_q == CH_ROLL))
    else $error("channel counter not rewound");

endmodule

/* design/rc_stick_conditioner_top.sv */
// Channel   | Dir | Handshake        | Contents
// in_i      | in  | valid/ready      | op, five raw channels, failsafe flag
// out_o     | out | valid/ready      | filtered roll/pitch/throttle/yaw, signal_lost, armed
// cfg       | in  | write enable     | cfg_idx_i selects one of eight registers
//
// A frame item raises valid on out_o once one shared 25x20 multiplier has served
// three steps for each of the four channels, each followed by a write-back step,
// and a done state has loaded the output. A tick item goes straight to the done state.
// Reset clears the filters, the held flags and the controller, and saturates
// the millisecond counter. A new item is taken while an earlier result still
// waits on out_o; a finished result then waits until the output register frees.
module rc_stick_conditioner_top import rcsc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  rcsc_in_if.sink               in_i,
  rcsc_out_if.source            out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  cfg_t    cfg;
  dp_cmd_t cmd;

  rcsc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  rcsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_op_i     (in_i.op),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .cmd_o       (cmd)
  );

  rcsc_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cfg_i          (cfg),
    .roll_raw_i     (in_i.roll_raw),
    .pitch_raw_i    (in_i.pitch_raw),
    .throttle_raw_i (in_i.throttle_raw),
    .yaw_raw_i      (in_i.yaw_raw),
    .arm_raw_i      (in_i.arm_raw),
    .failsafe_in_i  (in_i.failsafe_in),
    .roll_out_o     (out_o.roll_out),
    .pitch_out_o    (out_o.pitch_out),
    .throttle_out_o (out_o.throttle_out),
    .yaw_out_o      (out_o.yaw_out),
    .signal_lost_o  (out_o.signal_lost),
    .armed_o        (out_o.armed)
  );

endmodule

/* tb/rcsc_stick_checker.sv */
module rcsc_stick_checker import rcsc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  rcsc_in_if                    in_i,
  rcsc_out_if                   out_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int                    outstanding_o,
  output int                    errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [OUT_W-1:0] roll;
    logic signed [OUT_W-1:0] pitch;
    logic        [THR_W-1:0] throttle;
    logic signed [OUT_W-1:0] yaw;
    logic                    lost;
    logic                    armed;
  } sticks_t;

  sticks_t pending_sticks[$];
  cfg_t    regs;

  longint          roll_filt, pitch_filt, throttle_filt, yaw_filt;
  logic [MS_W-1:0] ms_count;
  logic            failsafe_held, armed_held;

  int mismatch_count = 0;
  int pending_count  = 0;

  assign errors_o      = mismatch_count;
  assign outstanding_o = pending_count;

  task automatic report(string msg);
    $display("%0t ns: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Raw channel to a Q1.14 fraction clamped to 0..1.
  function automatic longint stick_fraction(logic [RAW_W-1:0] raw);
    longint f;
    if (raw < regs.in_min) return 0;
    f = (longint'(raw - regs.in_min) * longint'(regs.span_recip)) >>> 16;
    return (f > longint'(Q14_ONE)) ? longint'(Q14_ONE) : f;
  endfunction

  function automatic longint stick_bipolar(logic [RAW_W-1:0] raw, logic [15:0] gain);
    longint x, mag;
    x   = 2 * stick_fraction(raw) - longint'(Q14_ONE);
    mag = (x < 0) ? -x : x;
    if (mag < longint'(regs.deadband)) x = 0;
    return (x * longint'(gain)) >>> 12;
  endfunction

  function automatic longint stick_ema(longint x, longint prev);
    longint a;
    a = (regs.alpha > Q16_ONE) ? longint'(Q16_ONE) : longint'(regs.alpha);
    return (a * x + (longint'(Q16_ONE) - a) * prev) >>> 16;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sticks_t want;
    longint  thr;
    if (!rst_ni) begin
      regs.in_min     = 11'd172;
      regs.span_recip = 24'd670972;
      regs.deadband   = 15'd819;
      regs.alpha      = 17'd19661;
      regs.timeout_ms = 16'd100;
      regs.roll_gain  = 16'd4096;
      regs.pitch_gain = 16'd4096;
      regs.yaw_gain   = 16'd4096;
      roll_filt       = 0;
      pitch_filt      = 0;
      throttle_filt   = 0;
      yaw_filt        = 0;
      ms_count        = '1;
      failsafe_held   = 1'b0;
      armed_held      = 1'b0;
      pending_sticks.delete();
    end else begin
      if (out_i.valid && out_i.ready) begin
        if (pending_sticks.size() == 0) begin
          report("result arrived with no item outstanding");
        end else begin
          want = pending_sticks.pop_front();
          if (out_i.roll_out !== want.roll)
            report($sformatf("roll_out got %0d expected %0d", out_i.roll_out, want.roll));
          if (out_i.pitch_out !== want.pitch)
            report($sformatf("pitch_out got %0d expected %0d", out_i.pitch_out, want.pitch));
          if (out_i.throttle_out !== want.throttle)
            report($sformatf("throttle_out got %0d expected %0d",
                             out_i.throttle_out, want.throttle));
          if (out_i.yaw_out !== want.yaw)
            report($sformatf("yaw_out got %0d expected %0d", out_i.yaw_out, want.yaw));
          if (out_i.signal_lost !== want.lost)
            report($sformatf("signal_lost got %b expected %b", out_i.signal_lost, want.lost));
          if (out_i.armed !== want.armed)
            report($sformatf("armed got %b expected %b", out_i.armed, want.armed));
        end
      end

      if (in_i.valid && in_i.ready) begin
        if (in_i.op == OP_FRAME) begin
          thr = (stick_fraction(in_i.throttle_raw) * longint'(THROTTLE_GAIN_Q12)) >>> 12;
          roll_filt     = stick_ema(stick_bipolar(in_i.roll_raw, regs.roll_gain), roll_filt);
          pitch_filt    = stick_ema(stick_bipolar(in_i.pitch_raw, regs.pitch_gain), pitch_filt);
          throttle_filt = stick_ema(thr, throttle_filt);
          yaw_filt      = stick_ema(stick_bipolar(in_i.yaw_raw, regs.yaw_gain), yaw_filt);
          ms_count      = '0;
          failsafe_held = in_i.failsafe_in;
          armed_held    = (in_i.arm_raw > ARM_CHANNEL_THRESHOLD);
        end else if (ms_count != '1) begin
          ms_count = ms_count + 1'b1;
        end
        want.roll     = roll_filt[OUT_W-1:0];
        want.pitch    = pitch_filt[OUT_W-1:0];
        want.throttle = throttle_filt[THR_W-1:0];
        want.yaw      = yaw_filt[OUT_W-1:0];
        want.lost     = failsafe_held || (ms_count > regs.timeout_ms);
        want.armed    = armed_held;
        pending_sticks.push_back(want);
      end

      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_IN_MIN:     regs.in_min     = cfg_wdata_i[RAW_W-1:0];
          CFG_SPAN_RECIP: regs.span_recip = cfg_wdata_i[23:0];
          CFG_DEADBAND:   regs.deadband   = cfg_wdata_i[14:0];
          CFG_ALPHA:      regs.alpha      = cfg_wdata_i[16:0];
          CFG_TIMEOUT_MS: regs.timeout_ms = cfg_wdata_i[MS_W-1:0];
          CFG_ROLL_GAIN:  regs.roll_gain  = cfg_wdata_i[15:0];
          CFG_PITCH_GAIN: regs.pitch_gain = cfg_wdata_i[15:0];
          CFG_YAW_GAIN:   regs.yaw_gain   = cfg_wdata_i[15:0];
          default: ;
        endcase
      end
    end
    pending_count = pending_sticks.size();
  end

endmodule

/* tb/tb_rc_stick_conditioner_top.sv */
module tb_rc_stick_conditioner_top import rcsc_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 24;
  localparam int PHASES         = 12;
  localparam int PHASE_ITEMS    = 94;
  localparam int PHASE_KINDS [PHASES] = '{4, 1, 2, 4, 3, 4, 0, 4, 1, 4, 3, 4};

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  int                    outstanding;
  int                    errors;
  int                    quiet_cycles = 0;

  // When set, neither side inserts idle cycles.
  bit steady = 1'b0;

  logic [RAW_W-1:0] cur_in_min;
  logic [23:0]      cur_span;
  logic [14:0]      cur_deadband;
  logic [MS_W-1:0]  cur_timeout;

  rcsc_in_if  in_ch ();
  rcsc_out_if out_ch ();

  rc_stick_conditioner_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_ch),
    .out_o       (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  rcsc_stick_checker stick_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_ch),
    .out_i         (out_ch),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .outstanding_o (outstanding),
    .errors_o      (errors)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_rc_stick_conditioner_top NOT OK");
      $finish;
    end
  end

  function automatic int draw_gap();
    return steady ? 0 : $urandom_range(0, 13);
  endfunction

  // Raw values cluster around in_min and around the deadband edges, where the
  // arithmetic changes behavior.
  function automatic logic [RAW_W-1:0] pick_raw();
    longint t, r;
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? '1 : '0;
      1: r = longint'(cur_in_min) + int'($urandom_range(0, 4)) - 2;
      2, 3: begin
        t = 8192 + ($urandom_range(0, 1) ? 1 : -1)
                 * (longint'(cur_deadband) / 2 + int'($urandom_range(0, 3)) - 1);
        if (cur_span == 0) r = int'($urandom_range(0, 2047));
        else r = longint'(cur_in_min) + (t * 65536) / longint'(cur_span);
      end
      default: return RAW_W'($urandom());
    endcase
    if (r < 0) r = 0;
    if (r > 2047) r = 2047;
    return RAW_W'(r);
  endfunction

  function automatic logic [RAW_W-1:0] pick_arm();
    if ($urandom_range(0, 3) == 0) return RAW_W'(998 + $urandom_range(0, 5));
    return RAW_W'($urandom());
  endfunction

  // Called at a rising edge; returns at the edge that accepted the item with
  // valid still high, so a back-to-back item keeps it high.
  task automatic send_item(logic op, logic [RAW_W-1:0] roll, logic [RAW_W-1:0] pitch,
                           logic [RAW_W-1:0] thr, logic [RAW_W-1:0] yaw,
                           logic [RAW_W-1:0] arm, logic fs);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.op           <= op;
    in_ch.roll_raw     <= roll;
    in_ch.pitch_raw    <= pitch;
    in_ch.throttle_raw <= thr;
    in_ch.yaw_raw      <= yaw;
    in_ch.arm_raw      <= arm;
    in_ch.failsafe_in  <= fs;
    do @(negedge clk_i); while (in_ch.ready !== 1'b1);
    @(posedge clk_i);
  endtask

  task automatic send_tick();
    send_item(OP_TICK, pick_raw(), pick_raw(), pick_raw(), pick_raw(), pick_arm(),
              1'($urandom()));
  endtask

  task automatic send_frame();
    send_item(OP_FRAME, pick_raw(), pick_raw(), pick_raw(), pick_raw(), pick_arm(),
              ($urandom_range(0, 5) == 0));
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(negedge clk_i); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_setting(logic [RAW_W-1:0] in_min, logic [23:0] span,
                               logic [14:0] db, logic [16:0] alpha, logic [MS_W-1:0] timeout,
                               logic [15:0] rs, logic [15:0] ps, logic [15:0] ys);
    write_reg(CFG_IN_MIN, CFG_DATA_W'(in_min));
    write_reg(CFG_SPAN_RECIP, CFG_DATA_W'(span));
    write_reg(CFG_DEADBAND, CFG_DATA_W'(db));
    write_reg(CFG_ALPHA, CFG_DATA_W'(alpha));
    write_reg(CFG_TIMEOUT_MS, CFG_DATA_W'(timeout));
    write_reg(CFG_ROLL_GAIN, CFG_DATA_W'(rs));
    write_reg(CFG_PITCH_GAIN, CFG_DATA_W'(ps));
    write_reg(CFG_YAW_GAIN, CFG_DATA_W'(ys));
    cur_in_min   = in_min;
    cur_span     = span;
    cur_deadband = db;
    cur_timeout  = timeout;
  endtask

  task automatic choose_setting(int kind);
    int width;
    logic [RAW_W-1:0] lo;
    case (kind)
      0: apply_setting(11'd172, 24'd670972, 15'd819, 17'd19661, 16'd100,
                       16'd4096, 16'd4096, 16'd4096);
      1: apply_setting(RAW_W'($urandom()), 24'($urandom()), 15'($urandom()),
                       17'($urandom()),
                       $urandom_range(0, 1) ? 16'($urandom_range(0, 20)) : 16'($urandom()),
                       16'($urandom()), 16'($urandom()), 16'($urandom()));
      2: apply_setting('0, '0, '0, '0, '0, '0, '0, '0);
      3: apply_setting('1, '1, $urandom_range(0, 1) ? 15'd16384 : 15'h7FFF,
                       $urandom_range(0, 1) ? 17'd65536 : 17'h1FFFF, '1, '1, '1, '1);
      default: begin
        // A plausible stick range with moderate roll and pitch gains, any yaw gain and a short timeout.
        lo    = RAW_W'($urandom_range(0, 400));
        width = $urandom_range(300, 2047);
        apply_setting(lo, 24'((longint'(16384) * 65536) / width),
                      15'($urandom_range(0, 16384)),
                      $urandom_range(0, 3) == 0 ? 17'd65536 : 17'($urandom_range(0, 131071)),
                      16'($urandom_range(0, 30)),
                      16'($urandom_range(0, 12288)), 16'($urandom_range(0, 12288)),
                      16'($urandom()));
      end
    endcase
  endtask

  // Frames interleaved with bursts of ticks; below a timeout of 24 a burst can be long enough to cross it.
  task automatic run_random(int count);
    int left, burst;
    left = count;
    while (left > 0) begin
      if ($urandom_range(0, 59) == 0) drain();
      if ($urandom_range(0, 2) == 0) begin
        burst = $urandom_range(1, (cur_timeout < 24) ? int'(cur_timeout) + 3 : 4);
        repeat (burst) send_tick();
        left -= burst;
      end else begin
        send_frame();
        left--;
      end
    end
  endtask

  initial begin
    int gap;
    out_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(negedge clk_i); while (out_ch.valid !== 1'b1);
      @(posedge clk_i);
    end
  end

  initial begin
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = CFG_IN_MIN;
    cfg_wdata_i        = '0;
    in_ch.valid        = 1'b0;
    in_ch.op           = OP_FRAME;
    in_ch.roll_raw     = '0;
    in_ch.pitch_raw    = '0;
    in_ch.throttle_raw = '0;
    in_ch.yaw_raw      = '0;
    in_ch.arm_raw      = '0;
    in_ch.failsafe_in  = 1'b0;
    cur_in_min         = 11'd172;
    cur_span           = 24'd670972;
    cur_deadband       = 15'd819;
    cur_timeout        = 16'd100;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The counter starts saturated, so the signal reads as lost before any
    // frame; with the largest timeout it never counts as a timeout.
    send_tick();
    drain();
    apply_setting(11'd172, 24'd670972, 15'd819, 17'd19661, 16'hFFFF,
                  16'd4096, 16'd4096, 16'd4096);
    send_tick();
    send_tick();
    send_item(OP_FRAME, 11'd972, 11'd972, 11'd972, 11'd972, 11'd0, 1'b1);
    drain();

    // Field extremes, the exact deadband edges and the arm threshold.
    choose_setting(0);
    send_item(OP_FRAME, '0, '0, '0, '0, '0, 1'b0);
    send_item(OP_FRAME, '1, '1, '1, '1, '1, 1'b1);
    send_item(OP_FRAME, 11'd172, 11'd172, 11'd172, 11'd172, 11'd1000, 1'b0);
    send_item(OP_FRAME, 11'd171, 11'd171, 11'd171, 11'd171, 11'd1001, 1'b0);
    send_item(OP_FRAME, 11'd1012, 11'd1013, 11'd1772, 11'd932, 11'd1001, 1'b0);
    send_item(OP_FRAME, 11'd933, 11'd972, 11'd1773, 11'd1013, 11'd999, 1'b0);
    send_tick();
    send_tick();
    drain();

    // No smoothing, no deadband, full gains, zero timeout.
    apply_setting(11'd172, 24'd670972, 15'd0, 17'd65536, 16'd0,
                  16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(OP_FRAME, '1, '0, '1, 11'd972, 11'd1500, 1'b0);
    send_tick();
    send_item(OP_FRAME, '0, '1, '0, 11'd973, 11'd200, 1'b0);
    drain();

    // Alpha above one behaves as one.
    apply_setting(11'd172, 24'd670972, 15'd819, 17'd65537, 16'd2,
                  16'd4096, 16'd4096, 16'd4096);
    send_item(OP_FRAME, '1, '1, '1, '1, '1, 1'b0);
    send_item(OP_FRAME, '0, 11'd1300, '0, 11'd600, '0, 1'b0);
    repeat (3) send_tick();
    drain();

    for (int p = 0; p < PHASES; p++) begin
      steady = ($urandom_range(0, 3) == 0);
      choose_setting(PHASE_KINDS[p]);
      run_random(PHASE_ITEMS);
      drain();
    end

    if (errors == 0) begin
      $display("tb_rc_stick_conditioner_top OK");
    end else begin
      $display("tb_rc_stick_conditioner_top NOT OK");
    end
    $finish;
  end

endmodule

/* rc_stick_conditioner_top.f */
design/rcsc_pkg.sv
design/rcsc_if.sv
design/rcsc_cfg_regs.sv
design/rcsc_datapath.sv
design/rcsc_ctrl.sv
design/rc_stick_conditioner_top.sv
tb/rcsc_stick_checker.sv
tb/tb_rc_stick_conditioner_top.sv
